FILE: src/vpmw_pkg.sv
// Shared types, codes and byte functions of the VGA planar memory block.
package vpmw_pkg;

    localparam int PLANE_DEPTH_DEF = 65536;
    localparam int NUM_PLANES      = 4;

    // Access codes carried on the command field.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_SET_RESET        = 3'd0;
    localparam logic [2:0] REG_ENABLE_SET_RESET = 3'd1;
    localparam logic [2:0] REG_ROTATE_COUNT     = 3'd2;
    localparam logic [2:0] REG_LOGIC_FUNCTION   = 3'd3;
    localparam logic [2:0] REG_WRITE_MODE       = 3'd4;
    localparam logic [2:0] REG_READ_PLANE       = 3'd5;
    localparam logic [2:0] REG_WRITE_MASK       = 3'd6;
    localparam logic [2:0] REG_PLANE_ENABLE     = 3'd7;

    localparam logic [7:0] WRITE_MASK_RST   = 8'hFF;
    localparam logic [3:0] PLANE_ENABLE_RST = 4'hF;

    // Write modes.
    localparam logic [1:0] WMODE_0 = 2'd0;
    localparam logic [1:0] WMODE_1 = 2'd1;
    localparam logic [1:0] WMODE_2 = 2'd2;
    localparam logic [1:0] WMODE_3 = 2'd3;

    // Logic functions applied against the latch byte.
    localparam logic [1:0] LF_PASS = 2'd0;
    localparam logic [1:0] LF_AND  = 2'd1;
    localparam logic [1:0] LF_OR   = 2'd2;
    localparam logic [1:0] LF_XOR  = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic mem_rd;
        logic mem_wr;
        logic latch_fwd;
        logic latch_load;
        logic out_load;
        logic out_zero;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    function automatic logic [7:0] rot_right(input logic [7:0] d, input logic [2:0] r);
        logic [15:0] dd;
        dd = {d, d} >> r;
        return dd[7:0];
    endfunction

    function automatic logic [7:0] alu_byte(input logic [1:0] lf, input logic [7:0] v,
                                            input logic [7:0] lat);
        logic [7:0] res;
        case (lf)
            LF_AND:  res = v & lat;
            LF_OR:   res = v | lat;
            LF_XOR:  res = v ^ lat;
            default: res = v;
        endcase
        return res;
    endfunction

    // New byte of one plane for a write, merged with the latch byte.
    function automatic logic [7:0] plane_byte(input logic [1:0] mode, input logic [1:0] lf,
                                              input logic sr_bit, input logic esr_bit,
                                              input logic data_bit, input logic [7:0] rd,
                                              input logic [7:0] mask,
                                              input logic [7:0] lat);
        logic [7:0] nb;
        logic [7:0] msk;
        msk = mask;
        case (mode)
            WMODE_0:
            begin
                nb = alu_byte(lf, esr_bit ? {8{sr_bit}} : rd, lat);
            end
            WMODE_1:
            begin
                nb  = lat;
                msk = 8'hFF;
            end
            WMODE_2:
            begin
                nb = alu_byte(lf, {8{data_bit}}, lat);
            end
            default:
            begin
                nb  = alu_byte(lf, {8{sr_bit}}, lat);
                msk = rd & mask;
            end
        endcase
        return (nb & msk) | (lat & ~msk);
    endfunction

endpackage

FILE: src/vpmw_ctrl.sv
// Controller: clearing sequence, access pipeline and output handshake.
module vpmw_ctrl
    import vpmw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   s1_valid_reg, s1_valid_next;
    logic   s1_write_reg, s1_write_next;
    logic   out_valid_reg, out_valid_next;
    logic   s1_adv;
    logic   acc;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != ST_RUN) || (s1_valid_reg && !s1_adv);
    assign acc      = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_write_next  = s1_write_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (s1_adv)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        if (acc)
        begin
            s1_valid_next = 1'b1;
            s1_write_next = command;
        end
    end

    always_comb
    begin
        cmd.clear_wr   = (state_reg == ST_CLEAR);
        cmd.mem_rd     = acc && (command == CMD_READ);
        cmd.mem_wr     = acc && (command == CMD_WRITE);
        cmd.latch_fwd  = s1_valid_reg && (s1_write_reg == CMD_READ);
        cmd.latch_load = s1_adv && (s1_write_reg == CMD_READ);
        cmd.out_load   = s1_adv;
        cmd.out_zero   = (s1_write_reg == CMD_WRITE);
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            s1_valid_reg  <= 1'b0;
            s1_write_reg  <= CMD_READ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            s1_write_reg  <= s1_write_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // No transfer may be taken while the memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("input transfer possible during memory clear");

    // An item in the memory stage is never dropped while the output is blocked.
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("memory stage item lost under output stall");

    // Every accepted item occupies the memory stage in the next cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s1_valid_reg)
        else $error("accepted item missing from memory stage");

endmodule

FILE: src/vpmw_dp.sv
// Datapath: configuration registers, plane memory, latch and write-mode logic.
module vpmw_dp
    import vpmw_pkg::*;
#(
    parameter int PLANE_DEPTH = PLANE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic [15:0] address,
    input  logic [7:0] data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic [7:0] read_data
);

    localparam int ADDR_W = $clog2(PLANE_DEPTH);

    logic [3:0] set_reset_reg;
    logic [3:0] enable_set_reset_reg;
    logic [2:0] rotate_count_reg;
    logic [1:0] logic_function_reg;
    logic [1:0] write_mode_reg;
    logic [1:0] read_plane_reg;
    logic [7:0] write_mask_reg;
    logic [3:0] plane_enable_reg;

    logic [31:0]       mem [PLANE_DEPTH];
    logic [31:0]       mem_q_reg;
    logic [31:0]       latch_reg;
    logic [31:0]       latch_eff;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] addr_idx;
    logic [7:0]        rd;
    logic [31:0]       wr_word;
    logic [7:0]        out_data_reg, out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reset_reg        <= '0;
            enable_set_reset_reg <= '0;
            rotate_count_reg     <= '0;
            logic_function_reg   <= LF_PASS;
            write_mode_reg       <= WMODE_0;
            read_plane_reg       <= '0;
            write_mask_reg       <= WRITE_MASK_RST;
            plane_enable_reg     <= PLANE_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_RESET:        set_reset_reg        <= cfg_data[3:0];
                REG_ENABLE_SET_RESET: enable_set_reset_reg <= cfg_data[3:0];
                REG_ROTATE_COUNT:     rotate_count_reg     <= cfg_data[2:0];
                REG_LOGIC_FUNCTION:   logic_function_reg   <= cfg_data[1:0];
                REG_WRITE_MODE:       write_mode_reg       <= cfg_data[1:0];
                REG_READ_PLANE:       read_plane_reg       <= cfg_data[1:0];
                REG_WRITE_MASK:       write_mask_reg       <= cfg_data;
                REG_PLANE_ENABLE:     plane_enable_reg     <= cfg_data[3:0];
                default:              ;
            endcase
        end
    end

    // The plane depth must be a power of two, which the block does not check; the address wraps by truncation.
    assign addr_idx      = address[ADDR_W-1:0];
    assign clr_addr_next = clr_addr_reg + 1'b1;
    assign status.clear_last = (clr_addr_reg == ADDR_W'(PLANE_DEPTH - 1));

    // A write straight after a read sees that read's word before the latch loads it.
    assign latch_eff = cmd.latch_fwd ? mem_q_reg : latch_reg;
    assign rd        = rot_right(data, rotate_count_reg);

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            wr_word[8*p +: 8] = plane_byte(write_mode_reg, logic_function_reg,
                                           set_reset_reg[p], enable_set_reset_reg[p],
                                           data[p], rd, write_mask_reg,
                                           latch_eff[8*p +: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.mem_wr)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (plane_enable_reg[p])
                begin
                    mem[addr_idx][8*p +: 8] <= wr_word[8*p +: 8];
                end
            end
        end
        if (cmd.mem_rd)
        begin
            mem_q_reg <= mem[addr_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= '0;
        end
        else if (cmd.latch_load)
        begin
            latch_reg <= mem_q_reg;
        end
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        if (cmd.out_load)
        begin
            out_data_next = cmd.out_zero ? 8'h00 : mem_q_reg[8*read_plane_reg +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign read_data = out_data_reg;

endmodule

FILE: src/vga_planar_memory_write_read.sv
// Four-plane VGA video memory with latch and graphics write modes 0 to 3.
// Each access is one transfer on the input channel and gives one transfer on
// the output channel: the selected plane byte for a read, zero for a write.
// The block takes one access per clock while the output is not stalled. The
// memory word is registered at the input transfer and the selected byte is
// then registered into the output register, which drives the output transfer.
// A write directly behind a read uses that read's word as latch. After reset
// the memory is cleared one word per cycle, so input is stalled until every
// word is cleared; configuration writes are taken throughout.
// PLANE_DEPTH must be a power of two; the address wraps modulo the depth.
module vga_planar_memory_write_read
    import vpmw_pkg::*;
#(
    parameter int PLANE_DEPTH = PLANE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    vpmw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    vpmw_dp #(
        .PLANE_DEPTH (PLANE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .address   (address),
        .data      (data),
        .cmd       (cmd),
        .status    (status),
        .read_data (read_data)
    );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the four-plane VGA video memory and its write modes.
`timescale 1ns / 1ps

module testbench;
    import vpmw_pkg::*;

    localparam int PHASES      = 37;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_PHASE  = 5;
    localparam int NUM_ROWS    = 47;

    typedef struct packed {
        logic [3:0] set_reset;
        logic [3:0] enable_set_reset;
        logic [2:0] rotate_count;
        logic [1:0] logic_function;
        logic [1:0] write_mode;
        logic [1:0] read_plane;
        logic [7:0] write_mask;
        logic [3:0] plane_enable;
    } gc_regs_t;

    typedef enum bit {ROW_REG, ROW_ACCESS} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  dat;
        bit          typed;
        logic [7:0]  exp_val;
    } dir_row_t;

    // Register rows carry the value in dat. Access rows with typed set carry
    // an expectation that is obvious by inspection; the rest use the predictor.
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_ACCESS, '0, CMD_READ,  16'h0000, 8'h00, 1'b1, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'hFFFF, 8'h00, 1'b1, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0010, 8'hA5, 1'b1, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0010, 8'h00, 1'b1, 8'hA5},
        '{ROW_REG, REG_READ_PLANE, CMD_READ, 16'h0000, 8'hFF, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0010, 8'h00, 1'b1, 8'hA5},
        '{ROW_REG, REG_ROTATE_COUNT, CMD_READ, 16'h0000, 8'hFF, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'hFFFF, 8'h01, 1'b1, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'hFFFF, 8'h00, 1'b1, 8'h02},
        '{ROW_REG, REG_WRITE_MODE, CMD_READ, 16'h0000, 8'(WMODE_1), 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0010, 8'h00, 1'b1, 8'hA5},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0020, 8'h00, 1'b1, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0020, 8'h00, 1'b1, 8'hA5},
        '{ROW_REG, REG_WRITE_MODE, CMD_READ, 16'h0000, 8'(WMODE_2), 1'b0, 8'h00},
        '{ROW_REG, REG_ROTATE_COUNT, CMD_READ, 16'h0000, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_LOGIC_FUNCTION, CMD_READ, 16'h0000, 8'(LF_XOR), 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0030, 8'h0F, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0030, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_LOGIC_FUNCTION, CMD_READ, 16'h0000, 8'(LF_AND), 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0031, 8'hF0, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0031, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_LOGIC_FUNCTION, CMD_READ, 16'h0000, 8'(LF_OR), 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MASK, CMD_READ, 16'h0000, 8'h0F, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0032, 8'h55, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0032, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MODE, CMD_READ, 16'h0000, 8'(WMODE_0), 1'b0, 8'h00},
        '{ROW_REG, REG_SET_RESET, CMD_READ, 16'h0000, 8'h0F, 1'b0, 8'h00},
        '{ROW_REG, REG_ENABLE_SET_RESET, CMD_READ, 16'h0000, 8'h05, 1'b0, 8'h00},
        '{ROW_REG, REG_LOGIC_FUNCTION, CMD_READ, 16'h0000, 8'(LF_PASS), 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MASK, CMD_READ, 16'h0000, 8'hFF, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0040, 8'h3C, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0040, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_READ_PLANE, CMD_READ, 16'h0000, 8'h00, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0040, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MODE, CMD_READ, 16'h0000, 8'(WMODE_3), 1'b0, 8'h00},
        '{ROW_REG, REG_SET_RESET, CMD_READ, 16'h0000, 8'h0A, 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MASK, CMD_READ, 16'h0000, 8'hF0, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0041, 8'hFF, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0041, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_PLANE_ENABLE, CMD_READ, 16'h0000, 8'h00, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0010, 8'h00, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0010, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_PLANE_ENABLE, CMD_READ, 16'h0000, 8'h0F, 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MASK, CMD_READ, 16'h0000, 8'h00, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_WRITE, 16'h0010, 8'hFF, 1'b0, 8'h00},
        '{ROW_ACCESS, '0, CMD_READ,  16'h0010, 8'h00, 1'b0, 8'h00},
        '{ROW_REG, REG_WRITE_MASK, CMD_READ, 16'h0000, 8'hFF, 1'b0, 8'h00}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [15:0] address;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;

    // Predictor state: the four planes, the latch and the controller registers.
    logic [31:0] vram_model [0:65535];
    logic [31:0] latch_model;
    gc_regs_t    gc;

    logic [7:0]  exp_read_data [$];
    logic [7:0]  expected_byte;
    int          n_fail;
    bit          calm;
    bit          hold_req;
    logic [15:0] hot_base;

    vga_planar_memory_write_read uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .address   (address),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void gc_reg_write(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            REG_SET_RESET:        gc.set_reset        = val[3:0];
            REG_ENABLE_SET_RESET: gc.enable_set_reset = val[3:0];
            REG_ROTATE_COUNT:     gc.rotate_count     = val[2:0];
            REG_LOGIC_FUNCTION:   gc.logic_function   = val[1:0];
            REG_WRITE_MODE:       gc.write_mode       = val[1:0];
            REG_READ_PLANE:       gc.read_plane       = val[1:0];
            REG_WRITE_MASK:       gc.write_mask       = val;
            REG_PLANE_ENABLE:     gc.plane_enable     = val[3:0];
            default:              ;
        endcase
    endfunction

    // Applies one access to the predictor state and returns the byte on read_data.
    function automatic logic [7:0] vram_access(input logic cmd, input logic [15:0] addr,
                                               input logic [7:0] dat);
        logic [31:0] word;
        logic [7:0]  rot;
        logic [7:0]  lat;
        logic [7:0]  src;
        logic [7:0]  nb;
        logic [7:0]  msk;
        if (cmd == CMD_READ)
        begin
            latch_model = vram_model[addr];
            return latch_model[8 * gc.read_plane +: 8];
        end
        word = vram_model[addr];
        rot  = (dat >> gc.rotate_count) | (dat << (4'd8 - gc.rotate_count));
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            if (gc.plane_enable[p])
            begin
                lat = latch_model[8 * p +: 8];
                msk = gc.write_mask;
                if (gc.write_mode == WMODE_1)
                begin
                    nb  = lat;
                    msk = 8'hFF;
                end
                else
                begin
                    case (gc.write_mode)
                        WMODE_0: src = gc.enable_set_reset[p] ? {8{gc.set_reset[p]}} : rot;
                        WMODE_2: src = {8{dat[p]}};
                        default:
                        begin
                            src = {8{gc.set_reset[p]}};
                            msk = rot & gc.write_mask;
                        end
                    endcase
                    case (gc.logic_function)
                        LF_AND:  nb = src & lat;
                        LF_OR:   nb = src | lat;
                        LF_XOR:  nb = src ^ lat;
                        default: nb = src;
                    endcase
                end
                word[8 * p +: 8] = (nb & msk) | (lat & ~msk);
            end
        end
        vram_model[addr] = word;
        return 8'h00;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return hot_base + 16'($urandom_range(0, 7));
        if (r == 8)
            return 16'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    // Offers one access and waits for its transfer. Called and returns at a falling edge.
    task automatic send_access(input logic cmd, input logic [15:0] addr, input logic [7:0] dat,
                               input bit typed, input logic [7:0] typed_exp);
        int         gap;
        logic [7:0] pred;
        gap = 0;
        if (!calm && $urandom_range(0, 9) >= 5)
            gap = pick_idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        address  <= addr;
        data     <= dat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = vram_access(cmd, addr, dat);
        exp_read_data.push_back(typed ? typed_exp : pred);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_read_data.size() != 0)
            @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        gc_reg_write(idx, val);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = pick_idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_read_data.size() == 0)
            begin
                $error("read_data transfer with nothing expected: actual %02h", read_data);
                n_fail++;
            end
            else
            begin
                expected_byte = exp_read_data.pop_front();
                if (read_data !== expected_byte)
                begin
                    $error("read_data mismatch: expected %02h, actual %02h",
                           expected_byte, read_data);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        int         done_in_phase;
        int         kind;
        logic [7:0] v;
        logic [15:0] a;
        logic [15:0] b;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SET_RESET;
        cfg_data  = 8'h00;
        in_valid  = 1'b0;
        command   = CMD_READ;
        address   = 16'h0000;
        data      = 8'h00;
        n_fail    = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        hot_base  = 16'h0000;
        for (int i = 0; i < 65536; i++)
            vram_model[i] = 32'h0;
        latch_model = 32'h0;
        gc = '{4'h0, 4'h0, 3'd0, LF_PASS, WMODE_0, 2'd0, WRITE_MASK_RST, PLANE_ENABLE_RST};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first access waits out the memory clearing pass behind in_stall.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_REG)
            begin
                drain();
                reg_write(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].dat);
            end
            else
                send_access(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].dat,
                            DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp_val);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            calm = 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                if (ph == 0)
                    v = 8'h00;
                else if (ph == 1)
                    v = 8'hFF;
                else
                    v = 8'($urandom_range(0, 255));
                reg_write(3'(i), v);
            end
            hot_base = 16'($urandom_range(0, 65535));
            if (ph % 4 == 3)
                calm = 1'b1;
            if (ph == HOLD_PHASE)
            begin
                // Back-to-back accesses against a stalled output fill the pipeline.
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            done_in_phase = 0;
            while (done_in_phase < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                a    = pick_addr();
                b    = pick_addr();
                if (kind <= 6)
                begin
                    // A read loads the latch that the following write merges with.
                    send_access(CMD_READ, a, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                    send_access(CMD_WRITE, (kind <= 4) ? a : b, 8'($urandom_range(0, 255)),
                                1'b0, 8'h00);
                    done_in_phase += 2;
                end
                else
                begin
                    send_access((kind <= 8) ? CMD_READ : CMD_WRITE, a,
                                8'($urandom_range(0, 255)), 1'b0, 8'h00);
                    done_in_phase++;
                end
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (n_fail == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
